>>> design/bucketed_hash_map_assert.svh
// ----------------------------------------------------------------------------
// bucketed_hash_map assertion macros
// concurrent assertion wrappers shared by the checker of the hash map
// ----------------------------------------------------------------------------
`ifndef BUCKETED_HASH_MAP_ASSERT_SVH
`define BUCKETED_HASH_MAP_ASSERT_SVH

// same-cycle implication
`define BHM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bucketed_hash_map assertion failed");

// next-cycle implication
`define BHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bucketed_hash_map assertion failed");

`endif

>>> design/bhm_pkg.sv
// ----------------------------------------------------------------------------
// bhm_pkg
// field widths, operation and status codes, entry layout and the command and
// status groups between controller and datapath of the hash map
// ----------------------------------------------------------------------------
package bhm_pkg;

   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 31;
   localparam int VALUE_W  = 31;
   localparam int FOUND_W  = 32;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   localparam logic signed [FOUND_W-1:0] NONE_VALUE = '1;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic rd_issue;
      logic exec;
      logic clr_step;
   } cmd_type;

   typedef struct packed {
      logic mod_fast;
      logic mod_done;
      logic clr_last;
   } sts_type;

endpackage

>>> design/bhm_ctrl.sv
// ----------------------------------------------------------------------------
// bhm_ctrl
// sequencer of the hash map: clearing pass, request intake, remainder
// steps, bucket read and compare/write-back
// ----------------------------------------------------------------------------
module bhm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  bhm_pkg::sts_type sts,
   output bhm_pkg::cmd_type cmd,
   output logic             busy
);
   import bhm_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_MOD   = 4'b0100,
      ST_EXEC  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (sts.mod_fast) begin
                  cmd.rd_issue = 1'b1;
                  state_in     = ST_EXEC;
               end else begin
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_EXEC;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> design/bhm_dpath.sv
// ----------------------------------------------------------------------------
// bhm_dpath
// request registers, bucket remainder, bucket memory, way compare and
// write-back, response registers
// ----------------------------------------------------------------------------
module bhm_dpath #(
   parameter int NUM_BUCKETS = 128,
   parameter int WAYS        = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bhm_pkg::cmd_type                    cmd,
   output bhm_pkg::sts_type                    sts,
   input  logic [bhm_pkg::FUNC_W-1:0]          req_func,
   input  logic [bhm_pkg::KEY_W-1:0]           req_key,
   input  logic [bhm_pkg::VALUE_W-1:0]         req_value,
   output logic                                rsp_valid,
   output logic signed [bhm_pkg::FOUND_W-1:0]  rsp_found_value,
   output logic [bhm_pkg::STATUS_W-1:0]        rsp_status
);
   import bhm_pkg::*;

   localparam int BW   = $clog2(NUM_BUCKETS);
   localparam bit POW2 = (NUM_BUCKETS == (1 << BW));
   localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;

   logic [FUNC_W-1:0]  func_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;

   logic [BW-1:0] rd_addr;
   logic [BW-1:0] bucket;
   logic          mod_done;

   logic [BW-1:0] clr_ff, clr_in;

   entry_type [WAYS-1:0] entry_mem [NUM_BUCKETS];
   entry_type [WAYS-1:0] row_ff;
   entry_type [WAYS-1:0] new_row;
   entry_type [WAYS-1:0] wr_row;
   logic [BW-1:0]        wr_addr;
   logic                 wr_en;

   logic [WAYS-1:0]             hit_vec, free_vec;
   logic [WW-1:0]               hit_way, free_way;
   logic signed [FOUND_W-1:0]   found;
   logic [STATUS_W-1:0]         status;

   logic                        rsp_valid_ff;
   logic signed [FOUND_W-1:0]   found_ff;
   logic [STATUS_W-1:0]         status_ff;

   // request transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
   end

   // bucket index
   if (POW2) begin : g_mask
      assign rd_addr  = req_key[BW-1:0];
      assign bucket   = key_ff[BW-1:0];
      assign mod_done = 1'b1;
   end else begin : g_recip
      localparam int             SH         = KEY_W + BW;
      localparam logic [63:0]    RECIP_WIDE =
         ((64'd1 << SH) + 64'(NUM_BUCKETS - 1)) / 64'(NUM_BUCKETS);
      localparam logic [KEY_W:0] RECIP      = RECIP_WIDE[KEY_W:0];
      localparam logic [1:0]     MOD_STEPS  = 2'd2;

      logic [1:0]       cnt_ff, cnt_in;
      logic [2*KEY_W:0] prod;
      logic [BW-1:0]    quot_ff, quot_in;
      logic [BW-1:0]    back;
      logic [BW-1:0]    rem_ff, rem_in;

      // quotient by reciprocal multiply, then remainder by one subtract
      always_comb begin
         prod    = {1'b0, key_ff} * RECIP;
         quot_in = prod[SH+BW-1:SH];
         back    = BW'(quot_ff * BW'(NUM_BUCKETS));
         rem_in  = key_ff[BW-1:0] - back;
         cnt_in  = cnt_ff;
         if (cmd.load) begin
            cnt_in = MOD_STEPS;
         end else if (cmd.mod_step) begin
            cnt_in = cnt_ff - 2'd1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff <= '0;
         end else begin
            cnt_ff <= cnt_in;
         end
         if (cmd.mod_step) begin
            quot_ff <= quot_in;
            rem_ff  <= rem_in;
         end
      end

      assign rd_addr  = rem_ff;
      assign bucket   = rem_ff;
      assign mod_done = (cnt_ff == '0);
   end

   // clearing pass
   always_comb begin
      clr_in = clr_ff;
      if (cmd.clr_step) begin
         clr_in = clr_ff + BW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   assign sts.mod_fast = POW2;
   assign sts.mod_done = mod_done;
   assign sts.clr_last = (clr_ff == BW'(NUM_BUCKETS - 1));

   // way compare and update
   always_comb begin
      hit_vec  = '0;
      free_vec = '0;
      hit_way  = '0;
      free_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w]  = row_ff[w].valid && (row_ff[w].key == key_ff);
         free_vec[w] = !row_ff[w].valid;
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WW'(w);
         end
         if (free_vec[w]) begin
            free_way = WW'(w);
         end
      end
   end

   always_comb begin
      new_row = row_ff;
      found   = NONE_VALUE;
      status  = STATUS_MISSING;
      case (func_ff)
         FUNC_PUT: begin
            if (|hit_vec) begin
               new_row[hit_way].value = value_ff;
               status                 = STATUS_OK;
            end else if (|free_vec) begin
               new_row[free_way].valid = 1'b1;
               new_row[free_way].key   = key_ff;
               new_row[free_way].value = value_ff;
               status                  = STATUS_OK;
            end else begin
               status = STATUS_FULL;
            end
         end
         FUNC_GET: begin
            if (|hit_vec) begin
               found  = $signed({1'b0, row_ff[hit_way].value});
               status = STATUS_OK;
            end
         end
         FUNC_REMOVE: begin
            if (|hit_vec) begin
               new_row[hit_way] = '0;
               status           = STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   // bucket memory
   assign wr_en   = cmd.clr_step | cmd.exec;
   assign wr_addr = cmd.clr_step ? clr_ff : bucket;
   assign wr_row  = cmd.clr_step ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         row_ff <= entry_mem[rd_addr];
      end
   end

   // response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.exec;
      end
      if (cmd.exec) begin
         found_ff  <= found;
         status_ff <= status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_value = found_ff;
   assign rsp_status      = status_ff;

endmodule

>>> design/bucketed_hash_map.sv
// ----------------------------------------------------------------------------
// bucketed_hash_map
// Key-value store with put, get and remove. After reset the block clears its
// bucket memory, one bucket a cycle, with busy high. A request is taken when
// start is high and busy is low. When NUM_BUCKETS is a power of two a request
// is one bucket read, then a step that compares all ways and writes the
// bucket back. Otherwise the bucket index is first found by a reciprocal
// multiply and then a subtract, each registered, before the bucket read.
// The result shows on the rsp_ ports for one cycle, marked by rsp_valid, in
// the cycle after the write-back; it cannot be held off and must be taken
// then. A put into a full bucket is refused with status 2.
// ----------------------------------------------------------------------------
module bucketed_hash_map #(
   parameter int NUM_BUCKETS = 128,
   parameter int WAYS        = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bhm_pkg::FUNC_W-1:0]          req_func,
   input  logic [bhm_pkg::KEY_W-1:0]           req_key,
   input  logic [bhm_pkg::VALUE_W-1:0]         req_value,
   output logic                                rsp_valid,
   output logic signed [bhm_pkg::FOUND_W-1:0]  rsp_found_value,
   output logic [bhm_pkg::STATUS_W-1:0]        rsp_status
);
   import bhm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bhm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   bhm_dpath #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .WAYS        (WAYS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_found_value (rsp_found_value),
      .rsp_status      (rsp_status)
   );

endmodule

>>> design/bhm_checker.sv
// ----------------------------------------------------------------------------
// bhm_checker
// port-level checks of the hash map, bound to the top level
// ----------------------------------------------------------------------------
`include "bucketed_hash_map_assert.svh"

module bhm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic signed [bhm_pkg::FOUND_W-1:0]  rsp_found_value,
   input logic [bhm_pkg::STATUS_W-1:0]        rsp_status
);
   import bhm_pkg::*;

   logic rsp_miss;

   assign rsp_miss = rsp_valid && (rsp_status != STATUS_OK);

   // a transfer in makes the block busy
   `BHM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // the result strobe lasts one cycle
   `BHM_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // a result comes out with the block ready again
   `BHM_ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // only a hit carries a value
   `BHM_ASSERT_IMPLY(a_miss_none, clock, reset, rsp_miss, rsp_found_value == NONE_VALUE)

endmodule

bind bucketed_hash_map bhm_checker u_bhm_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_found_value (rsp_found_value),
   .rsp_status      (rsp_status)
);
